@@ design/brlb_pkg.sv @@
// ----------------------------------------------------------------------------
// brlb_pkg: shared types and constants
// Control word layout, microcode program, configuration record and the fixed
// arithmetic constants of the breath-reactive LED brightness block.
// ----------------------------------------------------------------------------
`default_nettype none

package brlb_pkg;

    // Defaults for the top-level parameters
    localparam int SAMPLE_BITS_DEF   = 12;
    localparam int GAMMA_ENTRIES_DEF = 256;
    localparam int SINE_ENTRIES_DEF  = 256;

    // Phase steps in Q32 turns per millisecond
    localparam logic [23:0] IDLE_STEP    = 24'd1367131;
    localparam logic [23:0] OVERLAY_STEP = 24'd8544566;

    // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x below 2^23
    localparam logic [23:0] RECIP_100   = 24'd10737419;
    localparam int          RECIP_SHIFT = 30;

    localparam int MID_Q16  = 50 * 65536;
    localparam int FULL_Q16 = 100 * 65536;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    // Remainder unit: four quotient bits per cycle over a 32-bit dividend
    localparam int REM_DIGIT = 4;
    localparam int REM_STEPS = 32 / REM_DIGIT;
    localparam int REM_CNT_W = $clog2(REM_STEPS + 1);

    // Register indexes
    localparam logic [2:0] REG_SMOOTHING_GAIN    = 3'd0;
    localparam logic [2:0] REG_BASELINE_GAIN     = 3'd1;
    localparam logic [2:0] REG_SENSITIVITY       = 3'd2;
    localparam logic [2:0] REG_MIN_BRIGHTNESS    = 3'd3;
    localparam logic [2:0] REG_IDLE_PEAK         = 3'd4;
    localparam logic [2:0] REG_OVERLAY_AMPLITUDE = 3'd5;
    localparam logic [2:0] REG_PAUSED_LEVEL      = 3'd6;
    localparam logic [2:0] REG_BLINK_PERIOD_MS   = 3'd7;

    typedef struct packed {
        logic [7:0]  smoothing_gain;
        logic [15:0] baseline_gain;
        logic [7:0]  sensitivity;
        logic [7:0]  min_brightness;
        logic [7:0]  idle_peak;
        logic [6:0]  overlay_amplitude;
        logic [7:0]  paused_level;
        logic [15:0] blink_period_ms;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        smoothing_gain:    8'd77,
        baseline_gain:     16'd328,
        sensitivity:       8'd8,
        min_brightness:    8'd10,
        idle_peak:         8'd100,
        overlay_amplitude: 7'd30,
        paused_level:      8'd20,
        blink_period_ms:   16'd500
    };

    // Datapath status seen by the sequencer's jump conditions
    typedef struct packed {
        logic ok;
        logic conn;
        logic overlay;
        logic blink;
        logic div_busy;
    } t_status;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_MUL_SMOOTH,
        OP_UPD_SMOOTH,
        OP_MUL_BASE,
        OP_UPD_BASE,
        OP_MUL_DEV,
        OP_CLAMP_NUM,
        OP_MUL_RECIP,
        OP_NORM,
        OP_MUL_GIDX,
        OP_GIDX,
        OP_GAMMA,
        OP_MUL_OV_PHASE,
        OP_MUL_SIDX,
        OP_SINE,
        OP_MUL_OV,
        OP_OVERLAY,
        OP_DIV_START,
        OP_BLINK,
        OP_MUL_ID_PHASE,
        OP_MUL_IDLE,
        OP_IDLE_OUT,
        OP_ZERO,
        OP_DONE
    } t_op;

    typedef enum logic [2:0] {
        C_NONE,
        C_ALWAYS,
        C_NOT_OK,
        C_NOT_CONN,
        C_NO_OVERLAY,
        C_NO_BLINK,
        C_DIV_BUSY,
        C_OUT_BUSY
    } t_cond;

    localparam int UCODE_DEPTH = 29;
    localparam int STEP_W      = $clog2(UCODE_DEPTH);

    typedef struct packed {
        t_op               op;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_cw;

    localparam logic [STEP_W-1:0] S_START = STEP_W'(0);
    localparam logic [STEP_W-1:0] S_BLINK = STEP_W'(18);
    localparam logic [STEP_W-1:0] S_WAIT  = STEP_W'(20);
    localparam logic [STEP_W-1:0] S_IDLE  = STEP_W'(22);
    localparam logic [STEP_W-1:0] S_ZERO  = STEP_W'(27);
    localparam logic [STEP_W-1:0] S_OUT   = STEP_W'(28);

    localparam t_cw UCODE [UCODE_DEPTH] = '{
        '{OP_NOP,          C_NOT_OK,     S_ZERO },  // 0
        '{OP_NOP,          C_NOT_CONN,   S_IDLE },  // 1
        '{OP_MUL_SMOOTH,   C_NONE,       S_START},  // 2
        '{OP_UPD_SMOOTH,   C_NONE,       S_START},  // 3
        '{OP_MUL_BASE,     C_NONE,       S_START},  // 4
        '{OP_UPD_BASE,     C_NONE,       S_START},  // 5
        '{OP_MUL_DEV,      C_NONE,       S_START},  // 6
        '{OP_CLAMP_NUM,    C_NONE,       S_START},  // 7
        '{OP_MUL_RECIP,    C_NONE,       S_START},  // 8
        '{OP_NORM,         C_NONE,       S_START},  // 9
        '{OP_MUL_GIDX,     C_NONE,       S_START},  // 10
        '{OP_GIDX,         C_NONE,       S_START},  // 11
        '{OP_GAMMA,        C_NO_OVERLAY, S_BLINK},  // 12
        '{OP_MUL_OV_PHASE, C_NONE,       S_START},  // 13
        '{OP_MUL_SIDX,     C_NONE,       S_START},  // 14
        '{OP_SINE,         C_NONE,       S_START},  // 15
        '{OP_MUL_OV,       C_NONE,       S_START},  // 16
        '{OP_OVERLAY,      C_NONE,       S_START},  // 17
        '{OP_NOP,          C_NO_BLINK,   S_OUT  },  // 18
        '{OP_DIV_START,    C_NONE,       S_START},  // 19
        '{OP_NOP,          C_DIV_BUSY,   S_WAIT },  // 20
        '{OP_BLINK,        C_ALWAYS,     S_OUT  },  // 21
        '{OP_MUL_ID_PHASE, C_NONE,       S_START},  // 22
        '{OP_MUL_SIDX,     C_NONE,       S_START},  // 23
        '{OP_SINE,         C_NONE,       S_START},  // 24
        '{OP_MUL_IDLE,     C_NONE,       S_START},  // 25
        '{OP_IDLE_OUT,     C_ALWAYS,     S_OUT  },  // 26
        '{OP_ZERO,         C_NONE,       S_START},  // 27
        '{OP_DONE,         C_OUT_BUSY,   S_OUT  }   // 28
    };

endpackage

`default_nettype wire

@@ design/brlb_rem.sv @@
// ----------------------------------------------------------------------------
// brlb_rem: iterative remainder unit
// 32-bit dividend modulo 16-bit divisor, four restoring steps per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module brlb_rem
    import brlb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_dividend,
    input  wire logic [15:0] i_divisor,
    output logic             o_busy,
    output logic [15:0]      o_rem
);

    logic [31:0]          r_src, n_src;
    logic [15:0]          r_rem, n_rem;
    logic [REM_CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        logic [16:0] tmp;
        logic [15:0] acc;
        tmp   = '0;
        acc   = r_rem;
        n_src = r_src;
        n_rem = r_rem;
        n_cnt = r_cnt;
        if (i_start) begin
            n_src = i_dividend;
            n_rem = '0;
            n_cnt = REM_CNT_W'(REM_STEPS);
        end else if (r_cnt != '0) begin
            for (int j = 0; j < REM_DIGIT; j++) begin
                tmp = {acc, r_src[31 - j]};
                if (tmp >= {1'b0, i_divisor}) begin
                    tmp = tmp - {1'b0, i_divisor};
                end
                acc = tmp[15:0];
            end
            n_rem = acc;
            n_src = {r_src[31-REM_DIGIT:0], REM_DIGIT'(0)};
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_src <= n_src;
        r_rem <= n_rem;
    end

    assign o_busy = (r_cnt != '0);
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

@@ design/brlb_seq.sv @@
// ----------------------------------------------------------------------------
// brlb_seq: microcode sequencer
// Step counter over the control ROM with conditional jumps; issues one
// datapath operation per cycle while an item is in work.
// ----------------------------------------------------------------------------
`default_nettype none

module brlb_seq
    import brlb_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_status i_status,
    input  wire logic    i_out_busy,
    output logic         o_busy,
    output t_op          o_op,
    output logic         o_result
);

    logic              r_busy, n_busy;
    logic [STEP_W-1:0] r_step, n_step;
    t_cw               cw;
    logic              jump;

    assign cw = UCODE[r_step];

    always_comb begin
        case (cw.cond)
            C_NONE:       jump = 1'b0;
            C_ALWAYS:     jump = 1'b1;
            C_NOT_OK:     jump = !i_status.ok;
            C_NOT_CONN:   jump = !i_status.conn;
            C_NO_OVERLAY: jump = !i_status.overlay;
            C_NO_BLINK:   jump = !i_status.blink;
            C_DIV_BUSY:   jump = i_status.div_busy;
            C_OUT_BUSY:   jump = i_out_busy;
            default:      jump = 1'b0;
        endcase
    end

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_step = S_START;
            end
        end else if (jump) begin
            n_step = cw.target;
        end else if (cw.op == OP_DONE) begin
            n_busy = 1'b0;
        end else begin
            n_step = r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= S_START;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
    end

    assign o_busy   = r_busy;
    assign o_op     = r_busy ? cw.op : OP_NOP;
    assign o_result = r_busy && (cw.op == OP_DONE) && !i_out_busy;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("item started while the sequencer is busy");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_step < STEP_W'(UCODE_DEPTH)))
        else $error("step counter outside the program");

    a_entry_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> (r_step == S_START))
        else $error("program not entered at its first step");

    a_result_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result |=> !r_busy)
        else $error("sequencer still busy after delivering a result");

endmodule

`default_nettype wire

@@ design/brlb_dp.sv @@
// ----------------------------------------------------------------------------
// brlb_dp: brightness datapath
// Working registers, one shared signed multiplier, gamma and sine ROMs and
// the remainder unit, all driven by the sequencer's operation code.
// ----------------------------------------------------------------------------
`default_nettype none

module brlb_dp
    import brlb_pkg::*;
#(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int GAMMA_ENTRIES = GAMMA_ENTRIES_DEF,
    parameter int SINE_ENTRIES  = SINE_ENTRIES_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_load,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire logic [31:0]            i_time_ms,
    input  wire logic                   i_sense_good,
    input  wire logic                   i_connected,
    input  wire logic                   i_recording,
    input  wire logic                   i_paused,
    input  wire t_cfg                   i_cfg,
    input  wire t_op                    i_op,
    output t_status                     o_status,
    output logic [7:0]                  o_brightness
);

    // Level width: integer part wide enough for the sample and for 2000
    localparam int LW    = ((SAMPLE_BITS > 11) ? SAMPLE_BITS : 11) + 16;
    localparam int MA_W  = (LW + 1 > 33) ? LW + 1 : 33;
    localparam int MB_W  = 25;
    localparam int PW    = MA_W + MB_W;
    localparam int VAL_W = 23;
    localparam int GI_W  = $clog2(GAMMA_ENTRIES);
    localparam int SI_W  = $clog2(SINE_ENTRIES);

    localparam logic [LW-1:0] LEVEL_RESET = LW'(2000) << 16;

    typedef logic [7:0]         t_gamma_rom [GAMMA_ENTRIES];
    typedef logic signed [16:0] t_sine_rom  [SINE_ENTRIES];

    // Largest y with (y/255)^5 <= (idx/d)^9, exact in integers
    function automatic logic [7:0] gamma_entry(input int idx);
        logic [159:0] rhs;
        logic [159:0] lhs;
        int d;
        int lo;
        int hi;
        int mid;
        int it;
        int j;
        d = GAMMA_ENTRIES - 1;
        if (idx >= d) begin
            return 8'd255;
        end
        rhs = 160'd1;
        for (j = 0; j < 5; j++) rhs = rhs * 160'd255;
        for (j = 0; j < 9; j++) rhs = rhs * 160'(idx);
        lo = 0;
        hi = 255;
        for (it = 0; it < 8; it++) begin
            if (lo < hi) begin
                mid = (lo + hi + 1) >> 1;
                lhs = 160'd1;
                for (j = 0; j < 5; j++) lhs = lhs * 160'(mid);
                for (j = 0; j < 9; j++) lhs = lhs * 160'(d);
                if (lhs <= rhs) lo = mid;
                else hi = mid - 1;
            end
        end
        return 8'(lo);
    endfunction

    // Q1.15 sine by quadrant folding and a Q30 Taylor series
    function automatic logic signed [16:0] sine_entry(input int k);
        logic [63:0]        f;
        logic [63:0]        u;
        logic [63:0]        theta;
        logic [63:0]        term;
        logic signed [63:0] s;
        logic [1:0]         quad;
        int                 n;
        f     = (64'(k) << 32) / SINE_ENTRIES;
        quad  = f[31:30];
        u     = {34'd0, f[29:0]};
        if (quad[0]) u = ONE_Q30 - u;
        theta = (u * HALF_PI_Q30) >> 30;
        term  = theta;
        s     = $signed(theta);
        for (n = 1; n <= 6; n++) begin
            term = (term * theta) >> 30;
            term = (term * theta) >> 30;
            case (n)
                1:       term = term / 6;
                2:       term = term / 20;
                3:       term = term / 42;
                4:       term = term / 72;
                5:       term = term / 110;
                default: term = term / 156;
            endcase
            if (n[0]) s = s - $signed(term);
            else s = s + $signed(term);
        end
        if (s < 0) s = 0;
        if (s > $signed(ONE_Q30)) s = $signed(ONE_Q30);
        s = (s + 64'sd16384) >>> 15;
        if (quad[1]) return 17'(-s);
        return 17'(s);
    endfunction

    function automatic t_gamma_rom build_gamma();
        t_gamma_rom rom;
        int i;
        for (i = 0; i < GAMMA_ENTRIES; i++) rom[i] = gamma_entry(i);
        return rom;
    endfunction

    function automatic t_sine_rom build_sine();
        t_sine_rom rom;
        int i;
        for (i = 0; i < SINE_ENTRIES; i++) rom[i] = sine_entry(i);
        return rom;
    endfunction

    localparam t_gamma_rom GAMMA_ROM = build_gamma();
    localparam t_sine_rom  SINE_ROM  = build_sine();

    // Item registers
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [31:0]            r_time;
    logic                   r_ok, r_conn, r_rec, r_pau;

    // State and working registers
    logic [LW-1:0]         r_smooth, n_smooth;
    logic [LW-1:0]         r_base, n_base;
    logic signed [PW-1:0]  r_prod, n_prod;
    logic [VAL_W-1:0]      r_val, n_val;
    logic [GI_W-1:0]       r_gidx, n_gidx;
    logic signed [16:0]    r_sine, n_sine;
    logic [7:0]            r_bright, n_bright;

    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [PW-1:0]   prod_full;
    logic signed [LW:0]     smooth_diff;
    logic signed [LW:0]     dev_diff;
    logic [LW-1:0]          sample_q;
    logic [16:0]            sine_mag;
    logic signed [17:0]     sine_off_s;
    logic signed [PW-1:0]   upd_sum;
    logic signed [PW-1:0]   num_sum;
    logic signed [PW-1:0]   gidx_sum;
    logic [7:0]             gamma_val;
    logic [7:0]             ov_p;
    logic signed [9:0]      ov_sum;
    logic [15:0]            rem;
    logic                   rem_busy;

    assign sample_q    = LW'({r_sample, 16'd0});
    assign smooth_diff = $signed({1'b0, sample_q}) - $signed({1'b0, r_smooth});
    assign dev_diff    = $signed({1'b0, r_smooth}) - $signed({1'b0, r_base});
    assign sine_mag    = r_sine[16] ? 17'(-r_sine) : 17'(r_sine);
    assign sine_off_s  = 18'(r_sine) + 18'sd32768;
    assign gamma_val   = GAMMA_ROM[r_gidx];
    assign ov_p        = r_prod[15 +: 8];
    assign prod_full   = PW'(mul_a) * PW'(mul_b);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_op)
            OP_MUL_SMOOTH: begin
                mul_a = MA_W'(smooth_diff);
                mul_b = MB_W'({1'b0, i_cfg.smoothing_gain});
            end
            OP_MUL_BASE: begin
                mul_a = MA_W'(dev_diff);
                mul_b = MB_W'({1'b0, i_cfg.baseline_gain});
            end
            OP_MUL_DEV: begin
                mul_a = MA_W'(dev_diff);
                mul_b = MB_W'({1'b0, i_cfg.sensitivity});
            end
            OP_MUL_RECIP: begin
                mul_a = MA_W'({1'b0, r_val});
                mul_b = MB_W'({1'b0, RECIP_100});
            end
            OP_MUL_GIDX: begin
                mul_a = MA_W'({1'b0, r_val[16:0]});
                mul_b = MB_W'(GAMMA_ENTRIES - 1);
            end
            OP_MUL_OV_PHASE: begin
                mul_a = MA_W'({1'b0, r_time});
                mul_b = MB_W'({1'b0, OVERLAY_STEP});
            end
            OP_MUL_ID_PHASE: begin
                mul_a = MA_W'({1'b0, r_time});
                mul_b = MB_W'({1'b0, IDLE_STEP});
            end
            OP_MUL_SIDX: begin
                mul_a = MA_W'({1'b0, r_prod[31:0]});
                mul_b = MB_W'(SINE_ENTRIES);
            end
            OP_MUL_OV: begin
                mul_a = MA_W'({1'b0, sine_mag});
                mul_b = MB_W'({1'b0, i_cfg.overlay_amplitude});
            end
            OP_MUL_IDLE: begin
                mul_a = MA_W'({1'b0, sine_off_s[16:0]});
                mul_b = MB_W'({1'b0, i_cfg.idle_peak});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_smooth = r_smooth;
        n_base   = r_base;
        n_prod   = r_prod;
        n_val    = r_val;
        n_gidx   = r_gidx;
        n_sine   = r_sine;
        n_bright = r_bright;
        upd_sum  = '0;
        num_sum  = r_prod + PW'(MID_Q16);
        gidx_sum = r_prod + PW'(32768);
        ov_sum   = r_sine[16] ? $signed({2'b00, r_bright}) - $signed({2'b00, ov_p})
                              : $signed({2'b00, r_bright}) + $signed({2'b00, ov_p});
        case (i_op)
            OP_MUL_SMOOTH, OP_MUL_BASE, OP_MUL_DEV, OP_MUL_RECIP, OP_MUL_GIDX,
            OP_MUL_OV_PHASE, OP_MUL_ID_PHASE, OP_MUL_SIDX, OP_MUL_OV,
            OP_MUL_IDLE: begin
                n_prod = prod_full;
            end
            OP_UPD_SMOOTH: begin
                upd_sum  = PW'($signed({1'b0, r_smooth})) + (r_prod >>> 8);
                n_smooth = upd_sum[LW-1:0];
            end
            OP_UPD_BASE: begin
                upd_sum = PW'($signed({1'b0, r_base})) + (r_prod >>> 16);
                n_base  = upd_sum[LW-1:0];
            end
            OP_CLAMP_NUM: begin
                if (num_sum < 0) begin
                    n_val = '0;
                end else if (num_sum > PW'(FULL_Q16)) begin
                    n_val = VAL_W'(FULL_Q16);
                end else begin
                    n_val = num_sum[VAL_W-1:0];
                end
            end
            OP_NORM: begin
                n_val = r_prod[RECIP_SHIFT +: VAL_W];
            end
            OP_GIDX: begin
                n_gidx = gidx_sum[16 +: GI_W];
            end
            OP_GAMMA: begin
                n_bright = (gamma_val < i_cfg.min_brightness) ? i_cfg.min_brightness
                                                              : gamma_val;
            end
            OP_SINE: begin
                n_sine = SINE_ROM[r_prod[32 +: SI_W]];
            end
            OP_OVERLAY: begin
                if (ov_sum < $signed({2'b00, i_cfg.min_brightness})) begin
                    n_bright = i_cfg.min_brightness;
                end else if (ov_sum > 10'sd255) begin
                    n_bright = 8'd255;
                end else begin
                    n_bright = ov_sum[7:0];
                end
            end
            OP_BLINK: begin
                // dark half of the period
                if (rem >= (i_cfg.blink_period_ms >> 1)) begin
                    n_bright = i_cfg.paused_level;
                end
            end
            OP_IDLE_OUT: begin
                n_bright = r_prod[23:16];
            end
            OP_ZERO: begin
                n_bright = 8'd0;
            end
            default: begin
                n_bright = r_bright;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth <= LEVEL_RESET;
            r_base   <= LEVEL_RESET;
        end else begin
            r_smooth <= n_smooth;
            r_base   <= n_base;
        end
        if (i_load) begin
            r_sample <= i_sample;
            r_time   <= i_time_ms;
            r_ok     <= i_sense_good;
            r_conn   <= i_connected;
            r_rec    <= i_recording;
            r_pau    <= i_paused;
        end
        r_prod   <= n_prod;
        r_val    <= n_val;
        r_gidx   <= n_gidx;
        r_sine   <= n_sine;
        r_bright <= n_bright;
    end

    brlb_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_op == OP_DIV_START),
        .i_dividend (r_time),
        .i_divisor  (i_cfg.blink_period_ms),
        .o_busy     (rem_busy),
        .o_rem      (rem)
    );

    assign o_status.ok       = r_ok;
    assign o_status.conn     = r_conn;
    assign o_status.overlay  = r_rec && !r_pau;
    assign o_status.blink    = r_pau && (i_cfg.blink_period_ms != 16'd0);
    assign o_status.div_busy = rem_busy;
    assign o_brightness      = r_bright;

endmodule

`default_nettype wire

@@ design/breath_reactive_led_brightness_top.sv @@
// ----------------------------------------------------------------------------
// breath_reactive_led_brightness_top: breath-reactive LED brightness
// Stream in thermistor samples with status flags, stream out LED duty values.
// ----------------------------------------------------------------------------
// The time from input transaction to output valid depends on the path that the
// program takes: sensors not ok, not connected, connected, or connected with
// the overlay; a paused blink adds a remainder pass, four bits per cycle.
// One item at a time; the next item is taken the cycle after the program hands
// its result to the output register.
// Synchronous active-low reset: configuration registers to defaults, both levels to 2000.
`default_nettype none

module breath_reactive_led_brightness_top
    import brlb_pkg::*;
#(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int GAMMA_ENTRIES = GAMMA_ENTRIES_DEF,
    parameter int SINE_ENTRIES  = SINE_ENTRIES_DEF,
    localparam int IN_DATA_W    = ((SAMPLE_BITS + 32 + 7) / 8) * 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // tdata: sample, time_ms, zero pad
    input  wire logic [IN_DATA_W-1:0] s_axis_tdata,
    // tuser: sense_good, connected, recording, paused
    input  wire logic [3:0]           s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // tdata: brightness
    output logic [7:0]                m_axis_tdata,
    input  wire logic                 i_cfg_we,
    input  wire logic [2:0]           i_cfg_index,
    input  wire logic [15:0]          i_cfg_data
);

    t_cfg       r_cfg, n_cfg;
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_data, n_out_data;

    logic       seq_busy;
    logic       seq_result;
    t_op        op;
    t_status    status;
    logic [7:0] brightness;
    logic       in_accept;
    logic       out_busy;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_busy  = r_out_valid && !m_axis_tready;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SMOOTHING_GAIN:    n_cfg.smoothing_gain    = i_cfg_data[7:0];
                REG_BASELINE_GAIN:     n_cfg.baseline_gain     = i_cfg_data;
                REG_SENSITIVITY:       n_cfg.sensitivity       = i_cfg_data[7:0];
                REG_MIN_BRIGHTNESS:    n_cfg.min_brightness    = i_cfg_data[7:0];
                REG_IDLE_PEAK:         n_cfg.idle_peak         = i_cfg_data[7:0];
                REG_OVERLAY_AMPLITUDE: n_cfg.overlay_amplitude = i_cfg_data[6:0];
                REG_PAUSED_LEVEL:      n_cfg.paused_level      = i_cfg_data[7:0];
                REG_BLINK_PERIOD_MS:   n_cfg.blink_period_ms   = i_cfg_data;
                default:               n_cfg = r_cfg;
            endcase
        end
    end

    // Output register: load a finished result, drop it once taken
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (seq_result) begin
            n_out_valid = 1'b1;
            n_out_data  = brightness;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= CFG_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_cfg       <= n_cfg;
            r_out_valid <= n_out_valid;
        end
        r_out_data <= n_out_data;
    end

    brlb_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_accept),
        .i_status   (status),
        .i_out_busy (out_busy),
        .o_busy     (seq_busy),
        .o_op       (op),
        .o_result   (seq_result)
    );

    brlb_dp #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .GAMMA_ENTRIES (GAMMA_ENTRIES),
        .SINE_ENTRIES  (SINE_ENTRIES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (in_accept),
        .i_sample     (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_time_ms    (s_axis_tdata[SAMPLE_BITS +: 32]),
        .i_sense_good (s_axis_tuser[0]),
        .i_connected  (s_axis_tuser[1]),
        .i_recording  (s_axis_tuser[2]),
        .i_paused     (s_axis_tuser[3]),
        .i_cfg        (r_cfg),
        .i_op         (op),
        .o_status     (status),
        .o_brightness (brightness)
    );

    assign s_axis_tready = !seq_busy;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire
